[hw/rtl/ats_pkg.sv]
// Shared types and constants for the address-to-symbol lookup block.
package ats_pkg;

  localparam int IDX_W  = 12;
  localparam int CNT_W  = 13;
  localparam int OFS_W  = 32;
  localparam int ADDR_W = 64;
  localparam int CODE_W = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [CODE_W-1:0] OC_FOUND     = 3'd0;
  localparam logic [CODE_W-1:0] OC_OUT_RANGE = 3'd1;
  localparam logic [CODE_W-1:0] OC_BEFORE    = 3'd2;
  localparam logic [CODE_W-1:0] OC_PAST_END  = 3'd3;
  localparam logic [CODE_W-1:0] OC_BAD_NAME  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_BASE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NAME_BYTES = 2'd2;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  typedef struct packed {
    logic [OFS_W-1:0] name;
    logic [OFS_W-1:0] size;
    logic [OFS_W-1:0] start;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHK0,
    S_CMP,
    S_EVAL,
    S_EARLY
  } state_t;

endpackage

[hw/rtl/ats_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ats_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/address_to_symbol_lookup.sv]
// Top level of the address-to-symbol lookup block.
// Entry-write requests store one symbol entry. A lookup request rebases the query
// address, checks entry 0, then runs a binary search over the first entry_count entries
// (clamped to MAX_ENTRIES) with one RAM read per probe, followed by one read of the hit
// entry. The input is not ready while a lookup runs; a finished result may wait in the
// output register while the next request is taken. Start offsets must be loaded in
// ascending order, and entries below entry_count must have been written.
module address_to_symbol_lookup #(
  parameter int MAX_ENTRIES = 4096
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [11:0] entry_index, [43:12] entry_start, [75:44] entry_size,
  // [107:76] entry_name_offset, [171:108] query_address, [175:172] zero
  input  logic [175:0] in_tdata,
  // [0] func
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [11:0] hit_index, [43:12] offset_in_symbol, [75:44] hit_name_offset, [79:76] zero
  output logic [79:0]  out_tdata,
  // [2:0] outcome
  output logic [2:0]   out_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  import ats_pkg::*;

  localparam int AW   = $clog2(MAX_ENTRIES);
  localparam int CW   = $clog2(MAX_ENTRIES + 1);
  localparam int CMPW = (CW > CNT_W) ? CW : CNT_W;

  // field unpacking
  logic [IDX_W-1:0]  f_index;
  logic [OFS_W-1:0]  f_start, f_size, f_name;
  logic [ADDR_W-1:0] f_query;

  assign f_index = in_tdata[11:0];
  assign f_start = in_tdata[43:12];
  assign f_size  = in_tdata[75:44];
  assign f_name  = in_tdata[107:76];
  assign f_query = in_tdata[171:108];

  // configuration
  logic [ADDR_W-1:0] base_r;
  logic [CNT_W-1:0]  count_r;
  logic [OFS_W-1:0]  name_bytes_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r       <= '0;
      count_r      <= '0;
      name_bytes_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BASE:       base_r       <= cfg_data;
        REG_COUNT:      count_r      <= cfg_data[CNT_W-1:0];
        REG_NAME_BYTES: name_bytes_r <= cfg_data[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  // entry RAM
  logic           in_acc;
  logic           ram_we;
  logic [AW-1:0]  ram_raddr;
  entry_t         ram_wdata, rd;
  logic           slot_ok;

  assign in_acc  = in_tvalid && in_tready;
  assign slot_ok = 32'(f_index) < 32'(MAX_ENTRIES);
  assign ram_we  = in_acc && (in_tuser == FUNC_WRITE) && slot_ok;
  assign ram_wdata = '{name: f_name, size: f_size, start: f_start};

  ats_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(f_index)),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd)
  );

  // sequencer
  state_t            state_r, state_nxt;
  logic [AW-1:0]     low_r, low_nxt, mid_r, mid_nxt;
  logic [CW-1:0]     high_r, high_nxt, cnt_r, cnt_nxt;
  logic [OFS_W-1:0]  want_r, want_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;

  logic              out_tvalid_r;
  logic [CODE_W-1:0] out_code_r, out_code_nxt;
  logic [IDX_W-1:0]  out_idx_r, out_idx_nxt;
  logic [OFS_W-1:0]  out_ofs_r, out_ofs_nxt, out_name_r, out_name_nxt;
  logic              out_load, out_free;

  logic [ADDR_W:0]   rel;
  logic              oor;
  logic [CMPW-1:0]   cnt_ext;
  logic [CW-1:0]     cnt_clamp;
  logic              le;
  logic [AW-1:0]     n_low, n_mid;
  logic [CW-1:0]     n_high, diff;
  logic [OFS_W-1:0]  delta;

  assign in_tready = (state_r == S_IDLE);
  assign out_free  = !out_tvalid_r || out_tready;

  assign rel       = {1'b0, f_query} - {1'b0, base_r};
  assign oor       = rel[ADDR_W] || (|rel[ADDR_W-1:OFS_W]);
  assign cnt_ext   = CMPW'(count_r);
  assign cnt_clamp = (cnt_ext > CMPW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : CW'(cnt_ext);

  assign le     = rd.start <= want_r;
  assign n_low  = le ? mid_r : low_r;
  assign n_high = le ? high_r : CW'(mid_r);
  assign diff   = n_high - CW'(n_low);
  assign n_mid  = AW'(CW'(n_low) + (diff >> 1));
  assign delta  = want_r - rd.start;

  always_comb begin
    state_nxt    = state_r;
    low_nxt      = low_r;
    mid_nxt      = mid_r;
    high_nxt     = high_r;
    cnt_nxt      = cnt_r;
    want_nxt     = want_r;
    code_nxt     = code_r;
    ram_raddr    = '0;
    out_load     = 1'b0;
    out_code_nxt = code_r;
    out_idx_nxt  = '0;
    out_ofs_nxt  = '0;
    out_name_nxt = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_tuser == FUNC_LOOKUP)) begin
          want_nxt = rel[OFS_W-1:0];
          cnt_nxt  = cnt_clamp;
          low_nxt  = '0;
          high_nxt = cnt_clamp;
          if (oor) begin
            code_nxt  = OC_OUT_RANGE;
            state_nxt = S_EARLY;
          end else if (cnt_clamp == '0) begin
            code_nxt  = OC_BEFORE;
            state_nxt = S_EARLY;
          end else begin
            state_nxt = S_CHK0;
          end
        end
      end
      S_CHK0: begin
        if (want_r < rd.start) begin
          code_nxt  = OC_BEFORE;
          state_nxt = S_EARLY;
        end else if (high_r > CW'(1)) begin
          mid_nxt   = AW'(high_r >> 1);
          ram_raddr = AW'(high_r >> 1);
          state_nxt = S_CMP;
        end else begin
          state_nxt = S_EVAL;
        end
      end
      S_CMP: begin
        low_nxt  = n_low;
        high_nxt = n_high;
        if (diff > CW'(1)) begin
          mid_nxt   = n_mid;
          ram_raddr = n_mid;
        end else begin
          ram_raddr = n_low;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        ram_raddr    = low_r;
        out_idx_nxt  = IDX_W'(low_r);
        out_ofs_nxt  = delta;
        out_name_nxt = rd.name;
        if (rd.size != '0 && delta >= rd.size) begin
          out_code_nxt = OC_PAST_END;
        end else if (rd.name >= name_bytes_r) begin
          out_code_nxt = OC_BAD_NAME;
        end else begin
          out_code_nxt = OC_FOUND;
        end
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_EARLY: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    low_r  <= low_nxt;
    mid_r  <= mid_nxt;
    high_r <= high_nxt;
    cnt_r  <= cnt_nxt;
    want_r <= want_nxt;
    code_r <= code_nxt;
    if (out_load) begin
      out_code_r <= out_code_nxt;
      out_idx_r  <= out_idx_nxt;
      out_ofs_r  <= out_ofs_nxt;
      out_name_r <= out_name_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_code_r;
  assign out_tdata  = {4'b0, out_name_r, out_ofs_r, out_idx_r};

  // probe strictly inside the live search window
  a_probe_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CMP |-> (low_r < mid_r) && (CW'(mid_r) < high_r))
    else $error("probe outside search window");

  // hit entry lies below the clamped count
  a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EVAL |-> CW'(low_r) < cnt_r)
    else $error("hit index beyond entry count");

  // entry writes never start a search
  a_write_no_search: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser == FUNC_WRITE) |=> state_r == S_IDLE)
    else $error("entry write left idle");

  // early outcomes carry zero payload
  a_early_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EARLY && out_load) |=>
      (out_tuser == OC_OUT_RANGE || out_tuser == OC_BEFORE) && out_tdata == '0)
    else $error("early outcome with payload");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the address-to-symbol lookup block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ats_pkg::*;

  localparam int TBL_DEPTH = 4096;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [IDX_W-1:0]  idx;
    logic [OFS_W-1:0]  ofs;
    logic [OFS_W-1:0]  nm;
  } hit_t;

  logic         clk = 1'b0;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [175:0] in_tdata;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [79:0]  out_tdata;
  logic [2:0]   out_tuser;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [1:0]   cfg_index;
  logic [63:0]  cfg_data;

  // mirror of the block's table and registers
  logic [OFS_W-1:0]  tbl_start [TBL_DEPTH];
  logic [OFS_W-1:0]  tbl_size  [TBL_DEPTH];
  logic [OFS_W-1:0]  tbl_name  [TBL_DEPTH];
  bit                tbl_ok    [TBL_DEPTH];
  logic [ADDR_W-1:0] m_base       = '0;
  logic [CNT_W-1:0]  m_count      = '0;
  logic [OFS_W-1:0]  m_name_bytes = '0;

  hit_t pending_hits [$];
  int   mismatches = 0;
  bit   steady     = 1'b0;

  address_to_symbol_lookup #(.MAX_ENTRIES(TBL_DEPTH)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int unsigned eff_count();
    return (m_count > TBL_DEPTH) ? TBL_DEPTH : m_count;
  endfunction

  // predecessor search over the mirrored table; safe drops if a never-written slot is read
  function automatic hit_t resolve_symbol(logic [ADDR_W-1:0] addr, output bit safe);
    hit_t             r;
    logic [63:0]      rel;
    logic [31:0]      want;
    logic [31:0]      delta;
    int unsigned      lo, hi, mid, cnt;
    r = '0;
    safe = 1'b1;
    if (addr < m_base) begin
      r.code = OC_OUT_RANGE;
      return r;
    end
    rel = addr - m_base;
    if (rel > 64'h0000_0000_FFFF_FFFF) begin
      r.code = OC_OUT_RANGE;
      return r;
    end
    want = rel[31:0];
    cnt = eff_count();
    if (cnt == 0) begin
      r.code = OC_BEFORE;
      return r;
    end
    safe = tbl_ok[0];
    if (want < tbl_start[0]) begin
      r.code = OC_BEFORE;
      return r;
    end
    lo = 0;
    hi = cnt;
    while (hi - lo > 1) begin
      mid = lo + (hi - lo) / 2;
      safe &= tbl_ok[mid];
      if (tbl_start[mid] <= want) lo = mid;
      else hi = mid;
    end
    delta = want - tbl_start[lo];
    r.idx = 12'(lo);
    r.ofs = delta;
    r.nm  = tbl_name[lo];
    if (tbl_size[lo] != 0 && delta >= tbl_size[lo]) r.code = OC_PAST_END;
    else if (tbl_name[lo] >= m_name_bytes) r.code = OC_BAD_NAME;
    else r.code = OC_FOUND;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] pick_size();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return $urandom;
      default: return $urandom_range(1, 4096);
    endcase
  endfunction

  function automatic logic [31:0] pick_name();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return $urandom_range(0, 32'hFFFF);
  endfunction

  task automatic push_req(logic f, logic [11:0] idx, logic [31:0] st, logic [31:0] sz,
                          logic [31:0] nm, logic [63:0] addr);
    int gap;
    bit ok;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= {4'b0, addr, nm, sz, st, idx};
    in_tuser  <= f;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    if (f == FUNC_LOOKUP) begin
      pending_hits.push_back(resolve_symbol(addr, ok));
    end else begin
      tbl_start[idx] = st;
      tbl_size[idx]  = sz;
      tbl_name[idx]  = nm;
      tbl_ok[idx]    = 1'b1;
    end
  endtask

  task automatic write_entry(logic [11:0] idx, logic [31:0] st, logic [31:0] sz,
                             logic [31:0] nm);
    push_req(FUNC_WRITE, idx, st, sz, nm, {$urandom, $urandom});
  endtask

  task automatic lookup(logic [63:0] addr);
    bit safe;
    void'(resolve_symbol(addr, safe));
    // a search that would touch a never-written slot is sent out of range instead
    if (!safe) addr = m_base + 64'h1_0000_0000;
    push_req(FUNC_LOOKUP, 12'($urandom), $urandom, $urandom, $urandom, addr);
  endtask

  // drop valid, let outstanding results drain, then let the block settle
  task automatic wait_idle();
    int spin;
    @(negedge clk);
    in_tvalid <= 1'b0;
    spin = 0;
    while (pending_hits.size() != 0 && spin < 20000) begin
      @(posedge clk);
      spin++;
    end
    if (pending_hits.size() != 0) begin
      $error("%0d results never arrived", pending_hits.size());
      mismatches++;
      pending_hits.delete();
    end
    repeat (24) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_BASE:       m_base = val;
      REG_COUNT:      m_count = val[CNT_W-1:0];
      REG_NAME_BYTES: m_name_bytes = val[31:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_table(int unsigned n, bit ordered, int unsigned span, logic [31:0] first);
    logic [31:0] s;
    int unsigned k;
    s = first;
    for (k = 0; k < n; k++) begin
      write_entry(12'(k), ordered ? s : $urandom, pick_size(), pick_name());
      s += ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, span);
    end
  endtask

  task automatic probe_anywhere();
    logic [63:0] addr;
    case ($urandom_range(0, 3))
      0: addr = {$urandom, $urandom};
      1: addr = m_base + 64'($urandom);
      2: addr = m_base - 64'($urandom_range(1, 16));
      default: addr = m_base + 64'h1_0000_0000 - 64'($urandom_range(0, 2));
    endcase
    lookup(addr);
  endtask

  // address at or around a loaded entry's edges
  task automatic probe_near_entry();
    int unsigned k, cnt;
    logic [63:0] off;
    cnt = eff_count();
    if (cnt == 0) begin
      probe_anywhere();
    end else begin
      k = $urandom_range(0, cnt - 1);
      // fall back to the dense block at the bottom of the table
      if (!tbl_ok[k]) k = k % 64;
      if (!tbl_ok[k]) begin
        probe_anywhere();
      end else begin
        case ($urandom_range(0, 5))
          0: off = '0;
          1: off = 64'(tbl_size[k]) - 64'd1;
          2: off = 64'(tbl_size[k]);
          3: off = 64'($urandom_range(0, tbl_size[k] + 32));
          4: off = '1;
          default: off = 64'($urandom_range(0, 64));
        endcase
        lookup(m_base + 64'(tbl_start[k]) + off);
      end
    end
  endtask

  task automatic test_empty_table();
    lookup(64'h0);
    lookup(64'h0000_0000_FFFF_FFFF);
    lookup(64'h0000_0001_0000_0000);
  endtask

  task automatic test_directed_cases();
    logic [63:0] b;
    b = 64'h0000_7F00_0000_1000;
    wait_idle();
    cfg_write(REG_BASE, b);
    cfg_write(REG_NAME_BYTES, 64'h100);
    write_entry(12'd0, 32'h10, 32'h20, 32'h0);
    write_entry(12'd1, 32'h40, 32'h0, 32'hFF);
    write_entry(12'd2, 32'h1000, 32'h1, 32'h100);
    write_entry(12'd3, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    write_entry(12'd4, 32'hFFFF_FFFF, 32'h1, 32'h80);
    wait_idle();
    cfg_write(REG_COUNT, 64'd5);
    lookup(b - 64'd1);
    lookup(b);
    lookup(b + 64'h10);
    lookup(b + 64'h2F);
    lookup(b + 64'h30);
    lookup(b + 64'h3F);
    lookup(b + 64'h40);
    lookup(b + 64'hFFF);
    lookup(b + 64'h1000);
    lookup(b + 64'h1001);
    lookup(b + 64'hFFFF_FFFE);
    lookup(b + 64'hFFFF_FFFF);
    lookup(b + 64'h1_0000_0000);
    lookup(64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  task automatic test_full_table();
    int          n;
    int unsigned k;
    wait_idle();
    // dense bottom block, then every slot that a search over the whole table
    // passes on its way down into the block or up to the last slot
    load_table(64, 1'b1, 1 << 19, 32'h0);
    for (k = 64; k <= TBL_DEPTH / 2; k = k * 2)
      write_entry(12'(k), 32'hC000_0000, pick_size(), pick_name());
    for (k = TBL_DEPTH * 3 / 4; k < TBL_DEPTH; k = k + (TBL_DEPTH - k + 1) / 2)
      write_entry(12'(k), 32'hC000_0000, pick_size(), pick_name());
    wait_idle();
    cfg_write(REG_BASE, 64'h0);
    cfg_write(REG_COUNT, 64'd4096);
    cfg_write(REG_NAME_BYTES, 64'hFFFF_FFFF);
    for (n = 0; n < 60; n++) probe_near_entry();
    wait_idle();
    // count beyond the table depth is clamped
    cfg_write(REG_COUNT, 64'h1FFF);
    for (n = 0; n < 20; n++) probe_near_entry();
    lookup(64'hFFFF_FFFF_FFFF_FFFF);
    wait_idle();
    cfg_write(REG_BASE, 64'hFFFF_FFFF_FFFF_FFFF);
    cfg_write(REG_NAME_BYTES, 64'h0);
    lookup(64'hFFFF_FFFF_FFFF_FFFF);
    lookup(64'h0);
    for (n = 0; n < 6; n++) probe_anywhere();
  endtask

  task automatic test_random_mix();
    int          ph, n, r;
    int unsigned cnt, k;
    logic [31:0] cnt_v, nb, lo_v, hi_v;
    logic [63:0] b;
    for (ph = 0; ph < 14; ph++) begin
      wait_idle();
      steady = (ph % 4 == 3);
      case ($urandom_range(0, 7))
        0: cnt_v = 0;
        1: cnt_v = $urandom_range(1, 3);
        2, 3, 4: cnt_v = $urandom_range(4, 64);
        5: cnt_v = $urandom_range(65, 4095);
        6: cnt_v = 4096;
        default: cnt_v = $urandom_range(4097, 8191);
      endcase
      case ($urandom_range(0, 5))
        0: b = '0;
        1: b = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 32'h0100_0000));
        2: b = {$urandom, $urandom};
        default: b = {16'h0, 16'($urandom), $urandom};
      endcase
      case ($urandom_range(0, 5))
        0: nb = '0;
        1: nb = '1;
        default: nb = $urandom_range(32'hA000, 32'h10000);
      endcase
      cfg_write(REG_BASE, b);
      cfg_write(REG_COUNT, {$urandom, 19'($urandom), cnt_v[12:0]});
      cfg_write(REG_NAME_BYTES, {$urandom, nb});
      if (cnt_v >= 1 && cnt_v <= 64 && $urandom_range(0, 3) != 0)
        load_table(cnt_v, $urandom_range(0, 4) != 0, 1 << 25, $urandom_range(0, 4096));
      cnt = eff_count();
      for (n = 0; n < 80; n++) begin
        if (ph == 5 && n == 50) wait_idle();
        r = $urandom_range(0, 99);
        if (r < 72) begin
          probe_near_entry();
        end else if (r < 84) begin
          probe_anywhere();
        end else if (r < 95 && cnt > 0) begin
          // rewrite in place, keeping the order of starts where it holds
          k = $urandom_range(0, cnt - 1);
          lo_v = (k == 0 || !tbl_ok[k-1]) ? 32'h0 : tbl_start[k-1];
          hi_v = (k + 1 < cnt && tbl_ok[k+1]) ? tbl_start[k+1] : 32'hFFFF_FFFF;
          write_entry(12'(k), $urandom_range(hi_v, lo_v), pick_size(), pick_name());
        end else begin
          write_entry(12'($urandom_range(0, TBL_DEPTH - 1)), $urandom, pick_size(), pick_name());
        end
      end
    end
    steady = 1'b0;
  endtask

  always @(posedge clk) begin
    hit_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_hits.size() == 0) begin
        $error("result with no request outstanding");
        mismatches++;
      end else begin
        e = pending_hits.pop_front();
        if (out_tuser !== e.code) begin
          $error("outcome: expected %0d, got %0d", e.code, out_tuser);
          mismatches++;
        end
        if (out_tdata[11:0] !== e.idx) begin
          $error("hit_index: expected %0d, got %0d", e.idx, out_tdata[11:0]);
          mismatches++;
        end
        if (out_tdata[43:12] !== e.ofs) begin
          $error("offset_in_symbol: expected %h, got %h", e.ofs, out_tdata[43:12]);
          mismatches++;
        end
        if (out_tdata[75:44] !== e.nm) begin
          $error("hit_name_offset: expected %h, got %h", e.nm, out_tdata[75:44]);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int hold;
    hold = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (steady) begin
        out_tready <= 1'b1;
      end else if (hold > 0) begin
        hold--;
      end else if (out_tready) begin
        hold = pick_gap();
        if (hold > 0) out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        hold = $urandom_range(0, 12);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_empty_table();
    test_directed_cases();
    test_full_table();
    test_random_mix();
    wait_idle();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
